// File: sv/tplfo_pkg.sv
// Shared types, constants, microcode and cosine table builder for the blended LFO.
`default_nettype none
package tplfo_pkg;

  localparam int PHASE_BITS        = 32;
  localparam int COSINE_TABLE_BITS = 10;
  localparam int LEVEL_BITS        = 16;

  localparam int STEP_W  = 32;
  localparam int FIELD_W = 16;
  localparam int NUM_CH  = 3;
  localparam int QTR     = 1 << COSINE_TABLE_BITS;

  localparam logic signed [FIELD_W-1:0] SYNC_THRESHOLD = 16'sd6554;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_B    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_C    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_EN   = 3'd6;

  localparam logic [15:0] LEVEL_MAX_RST = 16'h4000;
  localparam logic [15:0] LEVEL_MIN_RST = 16'hC000;

  // Output channel codes
  localparam logic [1:0] CH_A    = 2'd0;
  localparam logic [1:0] CH_B    = 2'd1;
  localparam logic [1:0] CH_C    = 2'd2;
  localparam logic [1:0] LAST_CH = CH_C;

  // Microprogram
  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] PC_LOOP = 3'd3;

  typedef enum logic [2:0] {
    OP_PHASE,
    OP_ROM,
    OP_COS,
    OP_MUL1,
    OP_ADDU,
    OP_MUL2,
    OP_FIN,
    OP_DONE
  } op_t;

  typedef struct packed {
    op_t             op;
    logic            loop;
    logic [PC_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    logic       active;
    op_t        op;
    logic [1:0] ch;
  } ctrl_t;

  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = '{op: OP_DONE, loop: 1'b0, target: '0};
    case (pc)
      3'd0: w.op = OP_PHASE;
      3'd1: w.op = OP_ROM;
      3'd2: w.op = OP_COS;
      3'd3: w.op = OP_MUL1;
      3'd4: w.op = OP_ADDU;
      3'd5: w.op = OP_MUL2;
      3'd6: w = '{op: OP_FIN, loop: 1'b1, target: PC_LOOP};
      3'd7: w.op = OP_DONE;
      default: w.op = OP_DONE;
    endcase
    return w;
  endfunction

  // Quarter-wave cosine table, Q1.15 magnitudes
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [14:0] cos_tab_t [0:QTR];

  function automatic logic [14:0] cos_entry(input int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] q;
    x    = (HALF_PI_Q30 * 64'(k)) >> COSINE_TABLE_BITS;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = $signed(term);
    term = ((term * x2) >> 30) / 64'd2;   sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd12;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd30;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd56;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd90;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd132; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd182; sum = sum - $signed(term);
    if (sum < 0) sum = 0;
    q = (sum + 64'sd16384) >>> 15;
    if (q > 64'sd32767) q = 64'sd32767;
    return q[14:0];
  endfunction

  function automatic cos_tab_t build_cos();
    cos_tab_t t;
    for (int k = 0; k <= QTR; k++) begin
      t[k] = cos_entry(k);
    end
    return t;
  endfunction

endpackage
`default_nettype wire

// File: sv/tplfo_if.sv
// Handshake channel interfaces: sync input, level output and configuration write.
`default_nettype none
interface tplfo_in_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  sync_sample;
  modport source (output valid, output sync_sample, input ready);
  modport sink   (input valid, input sync_sample, output ready);
endinterface

interface tplfo_out_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  out_a;
  logic signed [15:0]  out_b;
  logic signed [15:0]  out_c;
  modport source (output valid, output out_a, output out_b, output out_c, input ready);
  modport sink   (input valid, input out_a, input out_b, input out_c, output ready);
endinterface

interface tplfo_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: sv/tplfo_seq.sv
// Microcode sequencer: step counter, channel loop counter and control word decode.
`default_nettype none
module tplfo_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic            out_free,
  output tplfo_pkg::ctrl_t     ctrl,
  output logic                 busy
);
  import tplfo_pkg::*;

  logic            busy_r, busy_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [1:0]      ch_r, ch_nxt;
  ucw_t            uw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
      ch_r   <= CH_A;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
      ch_r   <= ch_nxt;
    end
  end

  always_comb begin
    uw       = ucode(pc_r);
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    ch_nxt   = ch_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        pc_nxt   = '0;
        ch_nxt   = CH_A;
      end
    end else if (uw.op == OP_DONE) begin
      // hold until the output register can take the beat
      if (out_free) busy_nxt = 1'b0;
    end else if (uw.loop && ch_r != LAST_CH) begin
      pc_nxt = uw.target;
      ch_nxt = 2'(ch_r + 2'd1);
    end else begin
      pc_nxt = PC_W'(pc_r + 1'b1);
    end
  end

  assign ctrl.active = busy_r;
  assign ctrl.op     = uw.op;
  assign ctrl.ch     = ch_r;
  assign busy        = busy_r;

endmodule
`default_nettype wire

// File: sv/three_phase_blended_lfo_core.sv
// Top level of the three-phase blended LFO: config registers, datapath and handshakes.
// A new sync beat is taken only once the last one is done; the rate is set by the shared multiplier,
//   which the microprogram runs twice per channel over a three-pass channel loop.
// A finished result waits in the output register while the next beat is accepted.
// Reset (rst_n low, synchronous): phases clear, the sync history reads high and the
//   config registers take their defaults; the cosine ROM is constant and needs no clearing.
`default_nettype none
module three_phase_blended_lfo_core (
  input  wire logic clk,
  input  wire logic rst_n,
  tplfo_in_if.sink    in_ch,
  tplfo_out_if.source out_ch,
  tplfo_cfg_if.sink   cfg_ch
);
  import tplfo_pkg::*;

  localparam int MA_W = 34;
  localparam int MB_W = (LEVEL_BITS + 1 > 17) ? LEVEL_BITS + 1 : 17;
  localparam int PW   = MA_W + MB_W;
  localparam int RW   = LEVEL_BITS + 3;
  localparam logic signed [RW-1:0] LevelHi = RW'((2 ** (LEVEL_BITS - 1)) - 1);
  localparam logic signed [RW-1:0] LevelLo = -RW'(2 ** (LEVEL_BITS - 1));
  localparam cos_tab_t CosRom = build_cos();

  // Configuration registers
  logic [31:0] step_a_r, step_b_r, step_c_r;
  logic [15:0] level_max_r, level_min_r, blend_r;
  logic        sync_en_r;

  // Oscillator state
  logic [PHASE_BITS-1:0] phase_a_r, phase_b_r, phase_c_r;
  logic                  was_high_r;
  logic                  sync_hi_r;

  // Datapath registers
  logic [14:0]              rom_q_r;
  logic signed [15:0]       cos_r;
  logic signed [PW-1:0]     prod_r;
  logic [32:0]              u_r;
  logic [FIELD_W-1:0]       res_r [NUM_CH];
  logic                     out_valid_r;
  logic [FIELD_W-1:0]       out_a_r, out_b_r, out_c_r;

  ctrl_t ctrl;
  logic  busy;
  logic  in_acc;
  logic  out_free;

  tplfo_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .out_free (out_free),
    .ctrl     (ctrl),
    .busy     (busy)
  );

  assign in_ch.ready  = !busy;
  assign in_acc       = in_ch.valid && !busy;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  // Configuration writes; unknown indexes drop silently
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_a_r    <= '0;
      step_b_r    <= '0;
      step_c_r    <= '0;
      level_max_r <= LEVEL_MAX_RST;
      level_min_r <= LEVEL_MIN_RST;
      blend_r     <= '0;
      sync_en_r   <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_STEP_A:    step_a_r    <= cfg_ch.data;
        REG_STEP_B:    step_b_r    <= cfg_ch.data;
        REG_STEP_C:    step_c_r    <= cfg_ch.data;
        REG_LEVEL_MAX: level_max_r <= cfg_ch.data[15:0];
        REG_LEVEL_MIN: level_min_r <= cfg_ch.data[15:0];
        REG_BLEND:     blend_r     <= cfg_ch.data[15:0];
        REG_SYNC_EN:   sync_en_r   <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // Latch the sync level on the input beat; advance or clear phases in the first step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_a_r  <= '0;
      phase_b_r  <= '0;
      phase_c_r  <= '0;
      was_high_r <= 1'b1;
      sync_hi_r  <= 1'b1;
    end else begin
      if (in_acc) sync_hi_r <= (in_ch.sync_sample >= SYNC_THRESHOLD);
      if (ctrl.active && ctrl.op == OP_PHASE) begin
        if (sync_en_r && !was_high_r && sync_hi_r) begin
          phase_a_r <= '0;
          phase_b_r <= '0;
          phase_c_r <= '0;
        end else begin
          phase_a_r <= phase_a_r + step_a_r[31 -: PHASE_BITS];
          phase_b_r <= phase_b_r + step_b_r[31 -: PHASE_BITS];
          phase_c_r <= phase_c_r + step_c_r[31 -: PHASE_BITS];
        end
        was_high_r <= sync_hi_r;
      end
    end
  end

  // Waves from the phase tops
  logic [15:0]        pa16, pb16, pc16;
  logic signed [15:0] saw, rsaw;
  logic [16:0]        rsaw_full;
  logic [1:0]         quad;
  logic [COSINE_TABLE_BITS-1:0] cidx;
  logic [COSINE_TABLE_BITS:0]   rom_addr;
  logic               cos_neg;

  assign pa16      = phase_a_r[PHASE_BITS-1 -: 16];
  assign pb16      = phase_b_r[PHASE_BITS-1 -: 16];
  assign pc16      = phase_c_r[PHASE_BITS-1 -: 16];
  assign saw       = $signed({~pa16[15], pa16[14:0]});
  assign rsaw_full = 17'h08000 - {1'b0, pb16};
  // zero phase would give +1.0 exactly: saturate
  assign rsaw      = (pb16 == 16'h0000) ? 16'sh7FFF : $signed(rsaw_full[15:0]);
  assign quad      = pc16[15:14];
  assign cidx      = pc16[13 -: COSINE_TABLE_BITS];
  assign rom_addr  = quad[0] ? (COSINE_TABLE_BITS+1)'(QTR) - {1'b0, cidx} : {1'b0, cidx};
  assign cos_neg   = quad[0] ^ quad[1];

  always_ff @(posedge clk) begin
    if (ctrl.active && ctrl.op == OP_ROM) rom_q_r <= CosRom[rom_addr];
  end

  // Level span
  logic signed [LEVEL_BITS-1:0] lo, hi;
  logic signed [LEVEL_BITS:0]   d;
  logic                         d_neg;
  logic [LEVEL_BITS:0]          dmag;

  assign lo    = $signed(LEVEL_BITS'(level_min_r));
  assign hi    = $signed(LEVEL_BITS'(level_max_r));
  assign d     = (LEVEL_BITS+1)'(hi) - (LEVEL_BITS+1)'(lo);
  assign d_neg = d[LEVEL_BITS];
  assign dmag  = d_neg ? (LEVEL_BITS+1)'(-d) : (LEVEL_BITS+1)'(d);

  // Wave pair for the current channel
  logic signed [15:0] w1, w2;
  logic signed [16:0] diff;

  always_comb begin
    case (ctrl.ch)
      CH_A:    begin w1 = saw;   w2 = rsaw;  end
      CH_B:    begin w1 = rsaw;  w2 = cos_r; end
      CH_C:    begin w1 = cos_r; w2 = saw;   end
      default: begin w1 = saw;   w2 = rsaw;  end
    endcase
  end

  assign diff = 17'(w2) - 17'(w1);

  // Shared multiplier: blend weight first, then level span
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;

  always_comb begin
    if (ctrl.op == OP_MUL2) begin
      mul_a = $signed(MA_W'(u_r));
      mul_b = $signed(MB_W'(dmag));
    end else begin
      mul_a = MA_W'(diff);
      mul_b = $signed(MB_W'(blend_r));
    end
  end

  // Mix and final mapping
  logic signed [MA_W-1:0]   mix_u;
  logic [PW-1:0]            rnd;
  logic [LEVEL_BITS:0]      t_mag;
  logic signed [LEVEL_BITS+1:0] t_s;
  logic signed [RW-1:0]     r_sum;
  logic [LEVEL_BITS-1:0]    r_sat;

  // w1*(1-b) + w2*b rewritten as w1 + (w2-w1)*b, offset to unsigned
  assign mix_u = (MA_W'(w1) <<< 16) + prod_r[MA_W-1:0] + $signed(MA_W'(34'h080000000));
  assign rnd   = $unsigned(prod_r) + PW'(64'h80000000);
  assign t_mag = rnd[32 +: LEVEL_BITS+1];
  assign t_s   = d_neg ? -$signed({1'b0, t_mag}) : $signed({1'b0, t_mag});
  assign r_sum = RW'(lo) + RW'(t_s);

  always_comb begin
    if (r_sum > LevelHi)      r_sat = LevelHi[LEVEL_BITS-1:0];
    else if (r_sum < LevelLo) r_sat = LevelLo[LEVEL_BITS-1:0];
    else                      r_sat = r_sum[LEVEL_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.active) begin
      case (ctrl.op)
        OP_COS:  cos_r  <= cos_neg ? -$signed({1'b0, rom_q_r}) : $signed({1'b0, rom_q_r});
        OP_MUL1: prod_r <= mul_a * mul_b;
        OP_ADDU: u_r    <= mix_u[32:0];
        OP_MUL2: prod_r <= mul_a * mul_b;
        OP_FIN:  res_r[ctrl.ch] <= FIELD_W'(r_sat);
        default: ;
      endcase
    end
  end

  // Output register: load the finished beat once the slot is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.active && ctrl.op == OP_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.active && ctrl.op == OP_DONE && out_free) begin
      out_a_r <= res_r[CH_A];
      out_b_r <= res_r[CH_B];
      out_c_r <= res_r[CH_C];
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_a = $signed(out_a_r);
  assign out_ch.out_b = $signed(out_b_r);
  assign out_ch.out_c = $signed(out_c_r);

endmodule
`default_nettype wire

// File: tb/tplfo_level_checker.sv
// Checker for the blended LFO: mirrors registers and phases, predicts each result beat, compares.
module tplfo_level_checker (
  input  logic clk,
  input  logic rst_n,
  tplfo_in_if  in_mon,
  tplfo_out_if out_mon,
  tplfo_cfg_if cfg_mon,
  output int   errors,
  output int   pending
);
  import tplfo_pkg::*;

  localparam logic [63:0] HALF_PI_Q30_C = 64'd1686629713;

  typedef struct packed {
    logic signed [15:0] lvl_a;
    logic signed [15:0] lvl_b;
    logic signed [15:0] lvl_c;
  } lfo_levels_t;

  lfo_levels_t levels_due[$];

  int cos_quarter [0:QTR];

  logic [31:0]           inc_a, inc_b, inc_c;
  logic [PHASE_BITS-1:0] acc_a, acc_b, acc_c;
  logic signed [15:0]    lvl_top, lvl_bottom;
  logic [15:0]           xfade;
  logic                  resync_en;
  logic                  sync_prev_high;

  // Taylor series of cos in Q2.30, rounded to nearest Q1.15 magnitudes.
  function automatic void fill_cos_quarter();
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    longint      q;
    for (int k = 0; k <= QTR; k++) begin
      x    = (HALF_PI_Q30_C * 64'(k)) >> COSINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = longint'(term);
      for (int n = 1; n <= 7; n++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      q = (sum + 16384) / 32768;
      if (q > 32767) q = 32767;
      cos_quarter[k] = int'(q);
    end
  endfunction

  function automatic int cos_wave(input logic [15:0] p);
    int idx;
    idx = int'(p[13:0]) >> (14 - COSINE_TABLE_BITS);
    case (p[15:14])
      2'd0:    cos_wave = cos_quarter[idx];
      2'd1:    cos_wave = -cos_quarter[QTR - idx];
      2'd2:    cos_wave = -cos_quarter[idx];
      default: cos_wave = cos_quarter[QTR - idx];
    endcase
  endfunction

  // Crossfade two Q1.15 waves, then map -1..1 onto bottom..top with round-half-away.
  function automatic logic signed [15:0] wave_level(input int w1, input int w2);
    longint      wt;
    longint      mix;
    longint      lo;
    longint      span;
    longint      t;
    longint      r;
    logic [63:0] u;
    wt   = longint'(xfade);
    mix  = longint'(w1) * (64'sd65536 - wt) + longint'(w2) * wt;
    u    = 64'(mix + (64'sd1 <<< 31));
    lo   = longint'(lvl_bottom);
    span = longint'(lvl_top) - lo;
    if (span >= 0) t = longint'((u * 64'(span) + (64'd1 << 31)) >> 32);
    else t = -longint'((u * 64'(-span) + (64'd1 << 31)) >> 32);
    r = lo + t;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %0s", $time, msg);
    errors++;
  endtask

  task automatic take_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
    case (idx)
      REG_STEP_A:    inc_a = d;
      REG_STEP_B:    inc_b = d;
      REG_STEP_C:    inc_c = d;
      REG_LEVEL_MAX: lvl_top = d[15:0];
      REG_LEVEL_MIN: lvl_bottom = d[15:0];
      REG_BLEND:     xfade = d[15:0];
      REG_SYNC_EN:   resync_en = d[0];
      default: ;
    endcase
  endtask

  task automatic advance_and_predict(input logic signed [15:0] sample);
    logic        high;
    int          saw;
    int          rsaw;
    int          cosw;
    lfo_levels_t lv;
    high = (sample >= SYNC_THRESHOLD);
    if (resync_en && !sync_prev_high && high) begin
      acc_a = '0;
      acc_b = '0;
      acc_c = '0;
    end else begin
      acc_a = acc_a + PHASE_BITS'(inc_a >> (32 - PHASE_BITS));
      acc_b = acc_b + PHASE_BITS'(inc_b >> (32 - PHASE_BITS));
      acc_c = acc_c + PHASE_BITS'(inc_c >> (32 - PHASE_BITS));
    end
    sync_prev_high = high;
    saw  = int'(acc_a[PHASE_BITS-1 -: 16]) - 32768;
    rsaw = 32768 - int'(acc_b[PHASE_BITS-1 -: 16]);
    if (rsaw > 32767) rsaw = 32767;
    cosw = cos_wave(acc_c[PHASE_BITS-1 -: 16]);
    lv.lvl_a = wave_level(saw, rsaw);
    lv.lvl_b = wave_level(rsaw, cosw);
    lv.lvl_c = wave_level(cosw, saw);
    levels_due.push_back(lv);
  endtask

  task automatic check_beat();
    lfo_levels_t want;
    if (levels_due.size() == 0) begin
      report_mismatch($sformatf("result beat (%0d %0d %0d) with nothing outstanding",
                                out_mon.out_a, out_mon.out_b, out_mon.out_c));
    end else begin
      want = levels_due.pop_front();
      if (out_mon.out_a !== want.lvl_a)
        report_mismatch($sformatf("out_a got %0d expected %0d", out_mon.out_a, want.lvl_a));
      if (out_mon.out_b !== want.lvl_b)
        report_mismatch($sformatf("out_b got %0d expected %0d", out_mon.out_b, want.lvl_b));
      if (out_mon.out_c !== want.lvl_c)
        report_mismatch($sformatf("out_c got %0d expected %0d", out_mon.out_c, want.lvl_c));
    end
  endtask

  initial begin
    fill_cos_quarter();
  end

  // Retire the result beat before queueing a new prediction on the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      inc_a          = '0;
      inc_b          = '0;
      inc_c          = '0;
      lvl_top        = LEVEL_MAX_RST;
      lvl_bottom     = LEVEL_MIN_RST;
      xfade          = '0;
      resync_en      = 1'b0;
      acc_a          = '0;
      acc_b          = '0;
      acc_c          = '0;
      sync_prev_high = 1'b1;
      levels_due.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) take_reg(cfg_mon.index, cfg_mon.data);
      if (out_mon.valid && out_mon.ready) check_beat();
      if (in_mon.valid && in_mon.ready) advance_and_predict(in_mon.sync_sample);
    end
    pending <= levels_due.size();
  end

endmodule

// File: tb/tb.sv
// Testbench top for the blended LFO core: clock, reset, stimulus, pacing and verdict.
module tb;
  import tplfo_pkg::*;

  // Index past the last register; the core must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int QUIET_LIMIT = 4000;
  // Items per random phase; eight phases make up the bulk of the run.
  localparam int PHASE_ITEMS = 250;

  typedef struct {
    logic [31:0] step_a;
    logic [31:0] step_b;
    logic [31:0] step_c;
    logic [15:0] lvl_max;
    logic [15:0] lvl_min;
    logic [15:0] blend;
    logic        sync_en;
  } lfo_setting_t;

  logic clk;
  logic rst_n;
  int   in_idle_pct;
  int   out_stall_pct;
  logic sync_hi;
  int   fails;
  int   outstanding;
  int   quiet_cycles;

  tplfo_in_if  in_ch();
  tplfo_out_if out_ch();
  tplfo_cfg_if cfg_ch();

  three_phase_blended_lfo_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tplfo_level_checker checker_i (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .cfg_mon (cfg_ch),
    .errors  (fails),
    .pending (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver side: drop ready at random, at the rate the current pace asks for.
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Watchdog: any accepted beat on any channel restarts the count.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Pacing modes: free running, sender idling, receiver stalling, both.
  task automatic set_pace(input int mode);
    case (mode)
      0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1:       begin in_idle_pct = 60; out_stall_pct = 0;  end
      2:       begin in_idle_pct = 0;  out_stall_pct = 60; end
      default: begin in_idle_pct = 24; out_stall_pct = 24; end
    endcase
  endtask

  // Offer one sync beat and hold it until accepted. Valid stays high on return so
  // back-to-back beats never lower and raise it in the same step.
  task automatic push_sync(input logic signed [15:0] s);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sync_sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Hold the sender off until every predicted result beat has come back. The first
  // edge lets the checker count a beat accepted on the edge we returned from.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Write every register plus the spare index. Narrow registers get random junk
  // in the unused upper data bits, which the core must drop.
  task automatic apply_setting(input lfo_setting_t s);
    cfg_beat(REG_STEP_A, s.step_a);
    cfg_beat(REG_STEP_B, s.step_b);
    cfg_beat(REG_STEP_C, s.step_c);
    cfg_beat(REG_LEVEL_MAX, {16'($urandom), s.lvl_max});
    cfg_beat(REG_LEVEL_MIN, {16'($urandom), s.lvl_min});
    cfg_beat(REG_BLEND, {16'($urandom), s.blend});
    cfg_beat(REG_SYNC_EN, {31'($urandom), s.sync_en});
    cfg_beat(REG_SPARE, $urandom);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_step();
    if ($urandom_range(1) == 0) return $urandom_range(32'h0400_0000);
    return $urandom;
  endfunction

  // Sync samples: mostly a square-ish wave with random content on each level so
  // that rising edges come often, plus threshold neighbors and raw noise.
  function automatic logic signed [15:0] pick_sync();
    int r;
    r = $urandom_range(99);
    if (r < 12) sync_hi = ~sync_hi;
    if (r >= 92) return 16'($urandom);
    if (r >= 86) return sync_hi ? SYNC_THRESHOLD : SYNC_THRESHOLD - 16'sd1;
    if (sync_hi) return 16'($urandom_range(32767, 6554));
    return 16'(int'($urandom_range(39321)) - 32768);
  endfunction

  initial begin
    lfo_setting_t s;

    // Drive the sender and configuration inputs to known values before the first edge.
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.sync_sample <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= '0;
    cfg_ch.data       <= '0;
    sync_hi           = 1'b0;
    set_pace(0);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Reset defaults first: steps are zero, so the outputs sit still.
    push_sync(16'sh7FFF);
    push_sync(16'sh7FFF);
    settle();

    // Enable sync while the history still reads high from reset: a high first
    // sample must not clear the phases. Then a low, the exact threshold (rising
    // edge, clear), a held high (no clear), the sign extremes and another rising edge.
    s = '{step_a: 32'h0100_0000, step_b: 32'h0080_0000, step_c: 32'h0400_0000,
          lvl_max: 16'h7FFF, lvl_min: 16'h8000, blend: 16'h0000, sync_en: 1'b1};
    apply_setting(s);
    push_sync(16'sd20000);
    push_sync(16'sd6553);
    push_sync(16'sd6554);
    push_sync(16'sh7FFF);
    push_sync(16'sh8000);
    push_sync(-16'sd1);
    push_sync(16'sd0);
    push_sync(16'sd6553);
    push_sync(16'sh7FFF);
    push_sync(16'sd6554);
    settle();

    // Inverted levels, full blend, quarter-turn cosine steps so each quadrant shows,
    // and a step of all ones (phase A walks backward by one).
    s = '{step_a: 32'hFFFF_FFFF, step_b: 32'h0000_0001, step_c: 32'h4000_0000,
          lvl_max: 16'h8000, lvl_min: 16'h7FFF, blend: 16'hFFFF, sync_en: 1'b1};
    apply_setting(s);
    set_pace(3);
    push_sync(16'sh8000);
    push_sync(16'sd6554);
    push_sync(16'sd100);
    push_sync(16'sh7FFF);
    push_sync(-16'sd5);
    push_sync(-16'sd6);
    push_sync(16'sd6554);
    settle();

    // Zero span with mid blend, sync disabled: an edge must not clear.
    s = '{step_a: $urandom, step_b: $urandom, step_c: $urandom,
          lvl_max: 16'sd1234, lvl_min: 16'sd1234, blend: 16'h8000, sync_en: 1'b0};
    apply_setting(s);
    push_sync(16'sd6553);
    push_sync(16'sh7FFF);
    push_sync(16'sh8000);

    // Random part: one register setting per phase, pace cycling through the modes.
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: s = '{step_a: 32'hFFFF_FFFF, step_b: 32'hFFFF_FFFF, step_c: 32'hFFFF_FFFF,
                 lvl_max: 16'h7FFF, lvl_min: 16'h8000, blend: 16'hFFFF, sync_en: 1'b1};
        1: s = '{step_a: 32'h0, step_b: 32'h0, step_c: 32'h0,
                 lvl_max: 16'h8000, lvl_min: 16'h7FFF, blend: 16'h0000, sync_en: 1'b0};
        default: begin
          s.step_a  = pick_step();
          s.step_b  = pick_step();
          s.step_c  = pick_step();
          s.lvl_max = 16'($urandom);
          s.lvl_min = 16'($urandom);
          s.blend   = 16'($urandom);
          s.sync_en = ($urandom_range(3) != 0);
        end
      endcase
      apply_setting(s);
      set_pace(ph % 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Now and then hold the sender until the pipeline has drained.
        if ($urandom_range(63) == 0) settle();
        push_sync(pick_sync());
      end
    end

    // Drain, then give the core time to show any stray result beat.
    settle();
    repeat (40) @(posedge clk);
    if (fails == 0 && outstanding == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
